// ----- hw/rtl/cst_pkg.sv -----
// Shared types, constants and the encoding decoder for the call-site table search.
// No dependencies; used by the front end, queue, back end, top level and bench.
package cst_pkg;

   typedef logic [63:0] word_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_FOUND       = 2'd0,
      ST_NONE        = 2'd1,
      ST_UNSUPPORTED = 2'd2
   } status_type;

   // configuration register indexes
   localparam logic [1:0] CSR_SITE_ENCODING = 2'd0;
   localparam logic [1:0] CSR_SEARCH_PC     = 2'd1;
   localparam logic [1:0] CSR_PAD_BASE      = 2'd2;

   localparam logic [7:0] ENC_OMIT      = 8'hFF;
   localparam logic [7:0] ENC_RESET     = 8'hFF;

   // low nibble of the pointer encoding
   localparam logic [3:0] FMT_ABSPTR  = 4'h0;
   localparam logic [3:0] FMT_ULEB128 = 4'h1;
   localparam logic [3:0] FMT_UDATA2  = 4'h2;
   localparam logic [3:0] FMT_UDATA4  = 4'h3;
   localparam logic [3:0] FMT_UDATA8  = 4'h4;
   localparam logic [3:0] FMT_SLEB128 = 4'h9;
   localparam logic [3:0] FMT_SDATA2  = 4'hA;
   localparam logic [3:0] FMT_SDATA4  = 4'hB;
   localparam logic [3:0] FMT_SDATA8  = 4'hC;

   localparam int unsigned LEB_CONT_BIT  = 7;
   localparam int unsigned LEB_SIGN_BIT  = 6;
   localparam logic [6:0]  LEB_STEP      = 7'd7;
   localparam logic [6:0]  LEB_SHIFT_MAX = 7'd64;

   localparam logic [1:0]  FIELD_ACTION  = 2'd3;

   typedef enum logic [2:0] {
      KIND_BAD,
      KIND_FIXU,
      KIND_FIXS,
      KIND_ULEB,
      KIND_SLEB
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] size;
   } fmt_type;

   // one record, error or end-of-table marker handed from front to back
   typedef struct packed {
      logic     rec;
      logic     err;
      logic     last;
      word_type start;
      word_type length;
      word_type pad;
   } entry_type;

   function automatic fmt_type fmt_decode(input logic [3:0] nib, input logic [3:0] abs_bytes);
      fmt_type f;
      f.size = 4'd0;
      f.kind = KIND_BAD;
      case (nib)
         FMT_ABSPTR:  begin f.kind = KIND_FIXU; f.size = abs_bytes; end
         FMT_ULEB128: begin f.kind = KIND_ULEB; end
         FMT_UDATA2:  begin f.kind = KIND_FIXU; f.size = 4'd2; end
         FMT_UDATA4:  begin f.kind = KIND_FIXU; f.size = 4'd4; end
         FMT_UDATA8:  begin f.kind = KIND_FIXU; f.size = 4'd8; end
         FMT_SLEB128: begin f.kind = KIND_SLEB; end
         FMT_SDATA2:  begin f.kind = KIND_FIXS; f.size = 4'd2; end
         FMT_SDATA4:  begin f.kind = KIND_FIXS; f.size = 4'd4; end
         FMT_SDATA8:  begin f.kind = KIND_FIXS; f.size = 4'd8; end
         default:     begin f.kind = KIND_BAD;  f.size = 4'd0; end
      endcase
      return f;
   endfunction

endpackage

// ----- hw/rtl/cst_req_if.sv -----
// Byte channel into the call-site table search.
// No dependencies.
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/cst_rsp_if.sv -----
// Result channel out of the call-site table search.
// No dependencies.
interface cst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] pad_address;

   modport source (output valid, output status, output pad_address, input ready);
   modport sink   (input valid, input status, input pad_address, output ready);
endinterface

// ----- hw/rtl/cst_csr_if.sv -----
// Register write channel of the call-site table search.
// No dependencies.
interface cst_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/cst_front.sv -----
// Front end: takes table bytes, decodes the three encoded values and the action
// index, and pushes record, error and end-of-table entries. Uses cst_pkg, cst_req_if.
module cst_front #(
   parameter int ADDR_WIDTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   cst_req_if.sink             req_if,
   input  logic [7:0]          encoding,
   input  logic                q_full,
   output logic                push,
   output cst_pkg::entry_type  push_entry
);

   localparam int ABYTES_RAW = ADDR_WIDTH / 8;
   localparam logic [3:0] ABYTES =
      4'((ABYTES_RAW > 8) ? 8 : ((ABYTES_RAW < 1) ? 1 : ABYTES_RAW));

   logic [1:0]        field_ff, field_in;
   logic [3:0]        byte_ff, byte_in;
   cst_pkg::word_type acc_ff, acc_in;
   logic [6:0]        shift_ff, shift_in;
   cst_pkg::word_type start_ff, start_in;
   cst_pkg::word_type len_ff, len_in;
   cst_pkg::word_type pad_ff, pad_in;

   logic              accept;
   logic              omit_now;
   cst_pkg::fmt_type  fmt;
   logic [1:0]        field_cur;
   cst_pkg::word_type start_cur, len_cur, pad_cur;
   cst_pkg::word_type fix_acc, fix_val;
   logic [3:0]        byte_nx;
   logic [6:0]        size_bits;
   logic [6:0]        sign_pos;
   cst_pkg::word_type leb_acc, leb_val;
   logic [6:0]        shift_sum, shift_nx;
   logic              store;
   cst_pkg::word_type store_val;
   logic              ev_rec, ev_err;
   logic [7:0]        b;

   assign b      = req_if.data_byte;
   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = !q_full;

   assign fmt      = cst_pkg::fmt_decode(encoding[3:0], ABYTES);
   // omitted encoding turns the three values into zeros that take no bytes
   assign omit_now = (encoding == cst_pkg::ENC_OMIT) && (field_ff != cst_pkg::FIELD_ACTION);
   assign field_cur = omit_now ? cst_pkg::FIELD_ACTION : field_ff;
   assign start_cur = omit_now ? '0 : start_ff;
   assign len_cur   = omit_now ? '0 : len_ff;
   assign pad_cur   = omit_now ? '0 : pad_ff;

   // fixed-size little-endian value
   assign fix_acc   = (byte_ff < 4'd8) ? (acc_ff | ({56'b0, b} << {byte_ff[2:0], 3'b000}))
                                       : acc_ff;
   assign byte_nx   = byte_ff + 4'd1;
   assign size_bits = {fmt.size, 3'b000};
   assign sign_pos  = size_bits - 7'd1;

   always_comb begin
      fix_val = fix_acc;
      if ((fmt.kind == cst_pkg::KIND_FIXS) && (fmt.size < 4'd8) && fix_acc[sign_pos[5:0]]) begin
         fix_val = fix_acc | (~64'b0 << size_bits[5:0]);
      end
   end

   // LEB128: bits past 64 drop, shift saturates
   assign leb_acc   = (shift_ff < cst_pkg::LEB_SHIFT_MAX)
                      ? (acc_ff | ({57'b0, b[6:0]} << shift_ff[5:0])) : acc_ff;
   assign shift_sum = shift_ff + cst_pkg::LEB_STEP;
   assign shift_nx  = (shift_sum > cst_pkg::LEB_SHIFT_MAX) ? cst_pkg::LEB_SHIFT_MAX : shift_sum;

   always_comb begin
      leb_val = leb_acc;
      if ((fmt.kind == cst_pkg::KIND_SLEB) && b[cst_pkg::LEB_SIGN_BIT]
          && (shift_nx < cst_pkg::LEB_SHIFT_MAX)) begin
         leb_val = leb_acc | (~64'b0 << shift_nx[5:0]);
      end
   end

   always_comb begin
      field_in  = field_cur;
      byte_in   = omit_now ? 4'd0 : byte_ff;
      acc_in    = omit_now ? '0 : acc_ff;
      shift_in  = omit_now ? 7'd0 : shift_ff;
      start_in  = start_cur;
      len_in    = len_cur;
      pad_in    = pad_cur;
      ev_rec    = 1'b0;
      ev_err    = 1'b0;
      store     = 1'b0;
      store_val = fix_val;

      if (field_cur != cst_pkg::FIELD_ACTION) begin
         case (fmt.kind)
            cst_pkg::KIND_FIXU, cst_pkg::KIND_FIXS: begin
               if (byte_nx >= fmt.size) begin
                  store     = 1'b1;
                  store_val = fix_val;
               end else begin
                  acc_in  = fix_acc;
                  byte_in = byte_nx;
               end
            end
            cst_pkg::KIND_ULEB, cst_pkg::KIND_SLEB: begin
               if (!b[cst_pkg::LEB_CONT_BIT]) begin
                  store     = 1'b1;
                  store_val = leb_val;
               end else begin
                  acc_in   = leb_acc;
                  shift_in = shift_nx;
               end
            end
            default: ev_err = 1'b1;
         endcase
         if (store) begin
            case (field_cur)
               2'd0:    start_in = store_val;
               2'd1:    len_in   = store_val;
               default: pad_in   = store_val;
            endcase
            field_in = field_cur + 2'd1;
            byte_in  = 4'd0;
            acc_in   = '0;
            shift_in = 7'd0;
         end
      end else if (!b[cst_pkg::LEB_CONT_BIT]) begin
         // action index ends the record
         ev_rec   = 1'b1;
         field_in = 2'd0;
         byte_in  = 4'd0;
         acc_in   = '0;
         shift_in = 7'd0;
      end

      if (req_if.last_byte) begin
         field_in = 2'd0;
         byte_in  = 4'd0;
         acc_in   = '0;
         shift_in = 7'd0;
         start_in = '0;
         len_in   = '0;
         pad_in   = '0;
      end
   end

   assign push              = accept && (ev_rec || ev_err || req_if.last_byte);
   assign push_entry.rec    = ev_rec;
   assign push_entry.err    = ev_err;
   assign push_entry.last   = req_if.last_byte;
   assign push_entry.start  = start_cur;
   assign push_entry.length = len_cur;
   assign push_entry.pad    = pad_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= 2'd0;
         byte_ff  <= 4'd0;
         acc_ff   <= '0;
         shift_ff <= 7'd0;
         start_ff <= '0;
         len_ff   <= '0;
         pad_ff   <= '0;
      end else if (accept) begin
         field_ff <= field_in;
         byte_ff  <= byte_in;
         acc_ff   <= acc_in;
         shift_ff <= shift_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

// ----- hw/rtl/cst_queue.sv -----
// Short register FIFO between the front and back ends.
// Uses cst_pkg for the entry type.
module cst_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cst_pkg::entry_type push_entry,
   input  logic               pop,
   output cst_pkg::entry_type head,
   output logic               empty,
   output logic               full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cst_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

endmodule

// ----- hw/rtl/cst_back.sv -----
// Back end: range test of each record against the instruction offset, search
// state per table, and the result register. Uses cst_pkg, cst_rsp_if.
module cst_back (
   input  logic               clock,
   input  logic               reset,
   input  cst_pkg::word_type  search_pc,
   input  cst_pkg::word_type  pad_base,
   input  logic               q_empty,
   input  cst_pkg::entry_type q_head,
   output logic               pop,
   cst_rsp_if.source          rsp_if
);

   typedef struct packed {
      logic              rec;
      logic              err;
      logic              last;
      logic              lo_ok;
      logic              pad_zero;
      cst_pkg::word_type range_end;
      cst_pkg::word_type pad_sum;
   } stage_type;

   logic                s1_valid_ff;
   stage_type           s1_ff, s1_in;
   logic                done_ff, done_in;
   logic                out_valid_ff;
   cst_pkg::status_type out_status_ff;
   cst_pkg::word_type   out_addr_ff;

   logic                adv;
   logic                hit;
   logic                emit;
   logic                done_mid;
   cst_pkg::status_type emit_status;
   cst_pkg::word_type   emit_addr;

   assign adv = !out_valid_ff || rsp_if.ready;
   assign pop = adv && !q_empty;

   // first stage: end of range, lower bound and pad address
   assign s1_in.rec       = q_head.rec;
   assign s1_in.err       = q_head.err;
   assign s1_in.last      = q_head.last;
   assign s1_in.lo_ok     = (q_head.start <= search_pc);
   assign s1_in.pad_zero  = (q_head.pad == '0);
   assign s1_in.range_end = q_head.start + q_head.length;
   assign s1_in.pad_sum   = pad_base + q_head.pad;

   assign hit = s1_ff.rec && s1_ff.lo_ok && (search_pc < s1_ff.range_end);

   always_comb begin
      emit        = 1'b0;
      emit_status = cst_pkg::ST_NONE;
      emit_addr   = '0;
      if (s1_valid_ff && !done_ff) begin
         if (s1_ff.err) begin
            emit        = 1'b1;
            emit_status = cst_pkg::ST_UNSUPPORTED;
         end else if (hit) begin
            emit = 1'b1;
            if (s1_ff.pad_zero) begin
               emit_status = cst_pkg::ST_NONE;
            end else begin
               emit_status = cst_pkg::ST_FOUND;
               emit_addr   = s1_ff.pad_sum;
            end
         end
      end
      done_mid = done_ff || emit;
      // end of table with nothing reported yet
      if (s1_valid_ff && s1_ff.last && !done_mid) begin
         emit        = 1'b1;
         emit_status = cst_pkg::ST_NONE;
         emit_addr   = '0;
      end
      done_in = (s1_valid_ff && s1_ff.last) ? 1'b0 : done_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop;
         done_ff      <= done_in;
         out_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff <= s1_in;
      end
      if (adv && emit) begin
         out_status_ff <= emit_status;
         out_addr_ff   <= emit_addr;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.status      = out_status_ff;
   assign rsp_if.pad_address = out_addr_ff;

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff != cst_pkg::ST_FOUND)) |-> (out_addr_ff == '0))
      else $error("nonzero pad address without a handler");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_valid_ff && s1_ff.last) |=> !done_ff)
      else $error("search state survived end of table");

   a_err_reports: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_valid_ff && !done_ff && s1_ff.err) |=>
         (out_valid_ff && (out_status_ff == cst_pkg::ST_UNSUPPORTED)))
      else $error("unsupported encoding not reported");

endmodule

// ----- hw/rtl/call_site_table_search_top.sv -----
// Top level of the call-site table search: register file, front end, queue, back end.
// Uses cst_pkg, cst_req_if, cst_rsp_if, cst_csr_if, cst_front, cst_queue, cst_back.
//
//   channel   dir   handshake        payload
//   req_if    in    valid / ready    data_byte[7:0], last_byte
//   rsp_if    out   valid / ready    status[1:0], pad_address[63:0]
//   csr_if    in    valid / ready    index[1:0], data[63:0]
//
// One table byte per cycle unless the queue is full; the front end decodes each byte
// in the cycle it is taken. A result passes the queue, s1_ff and output register.
// Synchronous reset with no clearing pass; csr_if is always ready.
// A stalled rsp_if fills the QUEUE_DEPTH-entry queue, then req_if.ready drops.
module call_site_table_search_top #(
   parameter int ADDR_WIDTH  = 64,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   cst_req_if.sink    req_if,
   cst_rsp_if.source  rsp_if,
   cst_csr_if.sink    csr_if
);

   logic [7:0]         encoding_ff;
   cst_pkg::word_type  search_pc_ff;
   cst_pkg::word_type  pad_base_ff;

   logic               push;
   cst_pkg::entry_type push_entry;
   logic               pop;
   cst_pkg::entry_type q_head;
   logic               q_empty;
   logic               q_full;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         encoding_ff  <= cst_pkg::ENC_RESET;
         search_pc_ff <= '0;
         pad_base_ff  <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            cst_pkg::CSR_SITE_ENCODING: encoding_ff  <= csr_if.data[7:0];
            cst_pkg::CSR_SEARCH_PC:     search_pc_ff <= csr_if.data;
            cst_pkg::CSR_PAD_BASE:      pad_base_ff  <= csr_if.data;
            default: ;
         endcase
      end
   end

   cst_front #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .encoding   (encoding_ff),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   cst_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   cst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .search_pc (search_pc_ff),
      .pad_base  (pad_base_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for call_site_table_search_top: streams call-site table bytes and
// checks every lookup result against an in-bench model of the table scan.
// Depends on cst_pkg, the cst_req_if / cst_rsp_if / cst_csr_if interfaces and the block.
module tb;

   localparam int ADDR_WIDTH    = 64;
   localparam int RANDOM_BYTES  = 1250;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 4000;

   localparam logic [1:0] FIELD_START  = 2'd0;
   localparam logic [1:0] FIELD_LENGTH = 2'd1;
   localparam logic [1:0] CSR_SPARE    = 2'd3;

   typedef struct packed {
      logic [7:0] value;
      logic       fin;
   } table_byte_type;

   typedef struct packed {
      cst_pkg::status_type status;
      cst_pkg::word_type   pad_address;
   } lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cst_req_if req_bus ();
   cst_rsp_if rsp_bus ();
   cst_csr_if csr_bus ();

   call_site_table_search_top #(.ADDR_WIDTH(ADDR_WIDTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   table_byte_type table_bytes[$];
   lookup_type     lookups_due[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_go = 1'b0;
   logic hold_taken = 1'b0;
   int hold_left = 0;
   int quiet = 0;
   int errors = 0;
   int bytes_taken = 0;
   int csr_writes = 0;
   int n_found = 0;
   int n_none = 0;
   int n_unsupported = 0;

   // register mirror and scan state of the model
   logic [7:0]        enc_cfg;
   cst_pkg::word_type ip_cfg;
   cst_pkg::word_type base_cfg;
   logic [1:0]        fld;
   logic [3:0]        nbyte;
   cst_pkg::word_type acc;
   int                shift;
   cst_pkg::word_type rstart;
   cst_pkg::word_type rlen;
   cst_pkg::word_type padoff;
   logic              scan_done;

   task automatic clear_scan();
      fld = FIELD_START;
      nbyte = '0;
      acc = '0;
      shift = 0;
      rstart = '0;
      rlen = '0;
      padoff = '0;
      scan_done = 1'b0;
   endtask

   task automatic commit_field(cst_pkg::word_type v);
      case (fld)
         FIELD_START:  rstart = v;
         FIELD_LENGTH: rlen = v;
         default:      padoff = v;
      endcase
      fld = fld + 2'd1;
      nbyte = '0;
      acc = '0;
      shift = 0;
   endtask

   task automatic scan_table_byte(input logic [7:0] b, input logic fin, output logic hit,
                                  output cst_pkg::status_type st,
                                  output cst_pkg::word_type addr);
      cst_pkg::kind_type k;
      int                sz;
      cst_pkg::word_type v;
      cst_pkg::word_type lim;
      hit = 1'b0;
      st = cst_pkg::ST_NONE;
      addr = '0;
      if (!scan_done) begin
         if (enc_cfg == cst_pkg::ENC_OMIT && fld != cst_pkg::FIELD_ACTION) begin
            rstart = '0;
            rlen = '0;
            padoff = '0;
            fld = cst_pkg::FIELD_ACTION;
            nbyte = '0;
            acc = '0;
            shift = 0;
         end
         if (fld != cst_pkg::FIELD_ACTION) begin
            sz = 0;
            case (enc_cfg[3:0])
               cst_pkg::FMT_ABSPTR: begin
                  k = cst_pkg::KIND_FIXU;
                  sz = (ADDR_WIDTH / 8 > 8) ? 8 : ADDR_WIDTH / 8;
               end
               cst_pkg::FMT_ULEB128: k = cst_pkg::KIND_ULEB;
               cst_pkg::FMT_UDATA2:  begin k = cst_pkg::KIND_FIXU; sz = 2; end
               cst_pkg::FMT_UDATA4:  begin k = cst_pkg::KIND_FIXU; sz = 4; end
               cst_pkg::FMT_UDATA8:  begin k = cst_pkg::KIND_FIXU; sz = 8; end
               cst_pkg::FMT_SLEB128: k = cst_pkg::KIND_SLEB;
               cst_pkg::FMT_SDATA2:  begin k = cst_pkg::KIND_FIXS; sz = 2; end
               cst_pkg::FMT_SDATA4:  begin k = cst_pkg::KIND_FIXS; sz = 4; end
               cst_pkg::FMT_SDATA8:  begin k = cst_pkg::KIND_FIXS; sz = 8; end
               default:              k = cst_pkg::KIND_BAD;
            endcase
            if (k == cst_pkg::KIND_BAD) begin
               hit = 1'b1;
               st = cst_pkg::ST_UNSUPPORTED;
               scan_done = 1'b1;
            end else if (k == cst_pkg::KIND_FIXU || k == cst_pkg::KIND_FIXS) begin
               if (nbyte < 4'd8)
                  acc = acc | (cst_pkg::word_type'(b) << (8 * nbyte));
               nbyte = nbyte + 4'd1;
               if (nbyte >= sz) begin
                  v = acc;
                  if (k == cst_pkg::KIND_FIXS && sz < 8 && v[8 * sz - 1])
                     v = v | (~64'd0 << (8 * sz));
                  commit_field(v);
               end
            end else begin
               if (shift < 64)
                  acc = acc | (cst_pkg::word_type'(b[6:0]) << shift);
               shift = (shift + 7 > 64) ? 64 : shift + 7;
               if (!b[7]) begin
                  v = acc;
                  // sign fill only while the value is narrower than 64 bits
                  if (k == cst_pkg::KIND_SLEB && b[6] && shift < 64)
                     v = v | (~64'd0 << shift);
                  commit_field(v);
               end
            end
         end else if (!b[7]) begin
            lim = rstart + rlen;
            if (rstart <= ip_cfg && ip_cfg < lim) begin
               hit = 1'b1;
               if (padoff == '0) begin
                  st = cst_pkg::ST_NONE;
               end else begin
                  st = cst_pkg::ST_FOUND;
                  addr = base_cfg + padoff;
               end
               scan_done = 1'b1;
            end else begin
               fld = FIELD_START;
               nbyte = '0;
               acc = '0;
               shift = 0;
            end
         end
      end
      if (fin) begin
         if (!hit && !scan_done) begin
            hit = 1'b1;
            st = cst_pkg::ST_NONE;
            addr = '0;
         end
         clear_scan();
      end
   endtask

   task automatic report(string what, cst_pkg::word_type got, cst_pkg::word_type want);
      $display("tb: MISMATCH %s got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   // byte driver; also tracks register writes and predicts on every accepted byte
   always @(posedge clock) begin : byte_driver
      logic                fire;
      logic                hit;
      cst_pkg::status_type st;
      cst_pkg::word_type   addr;
      table_byte_type      nxt;
      if (reset) begin
         enc_cfg = cst_pkg::ENC_RESET;
         ip_cfg = '0;
         base_cfg = '0;
         clear_scan();
         req_bus.valid <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               cst_pkg::CSR_SITE_ENCODING: enc_cfg = csr_bus.data[7:0];
               cst_pkg::CSR_SEARCH_PC:     ip_cfg = csr_bus.data;
               cst_pkg::CSR_PAD_BASE:      base_cfg = csr_bus.data;
               default: ;
            endcase
            csr_writes++;
         end
         fire = req_bus.valid && req_bus.ready;
         if (fire) begin
            scan_table_byte(req_bus.data_byte, req_bus.last_byte, hit, st, addr);
            if (hit)
               lookups_due.push_back('{status: st, pad_address: addr});
            bytes_taken++;
         end
         if (req_bus.valid && !fire) begin
            // transaction still waiting, hold it
         end else if (table_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = table_bytes.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.data_byte <= nxt.value;
            req_bus.last_byte <= nxt.fin;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor and receiver stall control
   always @(posedge clock) begin : result_monitor
      lookup_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            case (rsp_bus.status)
               cst_pkg::ST_FOUND:       n_found++;
               cst_pkg::ST_NONE:        n_none++;
               cst_pkg::ST_UNSUPPORTED: n_unsupported++;
               default: ;
            endcase
            if (lookups_due.size() == 0) begin
               report("unexpected result, status/pad", {62'd0, rsp_bus.status},
                      rsp_bus.pad_address);
            end else begin
               want = lookups_due.pop_front();
               if (rsp_bus.status !== want.status)
                  report("status", {62'd0, rsp_bus.status}, {62'd0, want.status});
               if (rsp_bus.pad_address !== want.pad_address)
                  report("pad_address", rsp_bus.pad_address, want.pad_address);
            end
         end
         if (hold_go && !hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("tb: watchdog, no transaction for %0d cycles", quiet);
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, cst_pkg::word_type val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // wait for the block to drain, then let it go quiet
   task automatic settle();
      while (table_bytes.size() != 0 || req_bus.valid || lookups_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic put_byte(logic [7:0] b, logic fin);
      table_bytes.push_back('{value: b, fin: fin});
   endtask

   task automatic mark_end();
      table_byte_type t;
      t = table_bytes.pop_back();
      t.fin = 1'b1;
      table_bytes.push_back(t);
   endtask

   task automatic put_value(logic [7:0] enc, cst_pkg::word_type v);
      int                 sz;
      int                 n;
      int                 total;
      logic               is_signed;
      logic signed [63:0] sv;
      cst_pkg::word_type  part;
      sv = v;
      is_signed = 1'b0;
      if (enc == cst_pkg::ENC_OMIT) return;
      case (enc[3:0])
         cst_pkg::FMT_ABSPTR:                      sz = ADDR_WIDTH / 8;
         cst_pkg::FMT_UDATA2, cst_pkg::FMT_SDATA2: sz = 2;
         cst_pkg::FMT_UDATA4, cst_pkg::FMT_SDATA4: sz = 4;
         cst_pkg::FMT_UDATA8, cst_pkg::FMT_SDATA8: sz = 8;
         cst_pkg::FMT_ULEB128:                     sz = 0;
         cst_pkg::FMT_SLEB128:                     begin sz = 0; is_signed = 1'b1; end
         default:                                  sz = -1;
      endcase
      if (sz > 0) begin
         for (int i = 0; i < sz; i++)
            put_byte(v[8 * i +: 8], 1'b0);
      end else if (sz < 0) begin
         repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
      end else begin
         n = 1;
         while (n < 10) begin
            part = is_signed ? cst_pkg::word_type'(sv >>> (7 * n)) : v >> (7 * n);
            if (!is_signed && part == '0) break;
            if (is_signed && ((part == '0 && !v[7 * n - 1]) || (part == '1 && v[7 * n - 1])))
               break;
            n++;
         end
         // now and then pad with extra groups, some reaching past bit 63
         total = ($urandom_range(0, 7) == 0) ? n + $urandom_range(1, 9) : n;
         for (int i = 0; i < total; i++) begin
            if (7 * i < 64)
               part = is_signed ? cst_pkg::word_type'(sv >>> (7 * i)) : v >> (7 * i);
            else
               part = cst_pkg::word_type'($urandom);
            put_byte({logic'(i < total - 1), part[6:0]}, 1'b0);
         end
      end
   endtask

   task automatic put_record(logic [7:0] enc, cst_pkg::word_type ip);
      cst_pkg::word_type s;
      cst_pkg::word_type l;
      cst_pkg::word_type p;
      int                off;
      int                n_act;
      logic [7:0]        b;
      case ($urandom_range(0, 5))
         0, 1: begin
            off = $urandom_range(0, 40);
            s = ip - cst_pkg::word_type'(off);
            l = cst_pkg::word_type'(off + 1 + $urandom_range(0, 40));
         end
         2: begin
            s = cst_pkg::word_type'($urandom_range(0, 5000));
            l = cst_pkg::word_type'($urandom_range(0, 500));
         end
         3: begin
            s = ip;
            l = '0;
         end
         default: begin
            s = {$urandom, $urandom};
            l = {$urandom, $urandom};
         end
      endcase
      case ($urandom_range(0, 3))
         0:       p = '0;
         1:       p = {$urandom, $urandom};
         default: p = cst_pkg::word_type'($urandom_range(1, 5000));
      endcase
      put_value(enc, s);
      put_value(enc, l);
      put_value(enc, p);
      n_act = $urandom_range(1, 3);
      for (int i = 0; i < n_act; i++) begin
         b = 8'($urandom);
         b[7] = (i < n_act - 1);
         put_byte(b, 1'b0);
      end
   endtask

   task automatic put_table(logic [7:0] enc, cst_pkg::word_type ip, logic cut);
      int first;
      first = table_bytes.size();
      repeat ($urandom_range(1, 4)) put_record(enc, ip);
      if (cut && table_bytes.size() - first > 1)
         repeat ($urandom_range(1, table_bytes.size() - first - 1)) void'(table_bytes.pop_back());
      mark_end();
   endtask

   initial begin : stimulus
      logic [3:0]        good_fmts[9];
      logic [3:0]        bad_fmts[7];
      logic [7:0]        enc;
      cst_pkg::word_type ip;
      cst_pkg::word_type base;
      int                rand_bytes;
      logic              pressed;
      good_fmts = '{cst_pkg::FMT_ABSPTR, cst_pkg::FMT_ULEB128, cst_pkg::FMT_UDATA2,
                    cst_pkg::FMT_UDATA4, cst_pkg::FMT_UDATA8, cst_pkg::FMT_SLEB128,
                    cst_pkg::FMT_SDATA2, cst_pkg::FMT_SDATA4, cst_pkg::FMT_SDATA8};
      bad_fmts = '{4'h5, 4'h6, 4'h7, 4'h8, 4'hD, 4'hE, 4'hF};
      rand_bytes = 0;
      pressed = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // encoding omitted after reset: records are action bytes only, never a match
      @(negedge clock);
      put_byte(8'h00, 1'b1);
      put_byte(8'h85, 1'b0);
      put_byte(8'h01, 1'b1);
      settle();
      // unsupported format, then bytes after the error are dropped
      write_reg(cst_pkg::CSR_SITE_ENCODING, 64'h0F);
      @(negedge clock);
      put_byte(8'h12, 1'b1);
      put_byte(8'h12, 1'b0);
      put_byte(8'h34, 1'b1);
      settle();
      // 2-byte unsigned hit with wrapping pad address, trailing byte dropped,
      // then a table that ends inside a record
      write_reg(cst_pkg::CSR_SITE_ENCODING, 64'(cst_pkg::FMT_UDATA2));
      write_reg(cst_pkg::CSR_SEARCH_PC, 64'd5);
      write_reg(cst_pkg::CSR_PAD_BASE, '1);
      @(negedge clock);
      put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
      put_byte(8'h10, 1'b0); put_byte(8'h00, 1'b0);
      put_byte(8'h03, 1'b0); put_byte(8'h00, 1'b0);
      put_byte(8'h00, 1'b0); put_byte(8'hAA, 1'b1);
      put_byte(8'h01, 1'b1);
      settle();
      // ULEB with redundant group; hit with zero pad means no handler
      write_reg(cst_pkg::CSR_SITE_ENCODING, 64'(cst_pkg::FMT_ULEB128));
      write_reg(cst_pkg::CSR_SEARCH_PC, '0);
      write_reg(CSR_SPARE, {$urandom, $urandom});
      @(negedge clock);
      put_byte(8'h80, 1'b0); put_byte(8'h00, 1'b0);
      put_byte(8'h01, 1'b0); put_byte(8'h00, 1'b0);
      put_byte(8'h00, 1'b1);
      settle();

      while (rand_bytes < RANDOM_BYTES) begin
         if (rand_bytes < RANDOM_BYTES / 3) begin
            send_idle_pct <= 11;
            recv_idle_pct <= 82;
         end else if (rand_bytes < 2 * RANDOM_BYTES / 3) begin
            send_idle_pct <= 82;
            recv_idle_pct <= 11;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
            if (!pressed) begin
               // receiver holds off while one-byte tables keep coming: queue fills
               pressed = 1'b1;
               @(negedge clock);
               repeat (40) put_byte(8'($urandom), 1'b1);
               rand_bytes += 40;
               hold_go <= 1'b1;
               settle();
            end
         end

         case ($urandom_range(0, 9))
            0:       enc = cst_pkg::ENC_OMIT;
            1:       enc = {4'($urandom), bad_fmts[$urandom_range(0, 6)]};
            2:       enc = 8'h00;
            default: enc = {4'($urandom), good_fmts[$urandom_range(0, 8)]};
         endcase
         case ($urandom_range(0, 5))
            0:       ip = '0;
            1:       ip = '1;
            2:       ip = 64'd0 - 64'($urandom_range(1, 3000));
            3, 4:    ip = cst_pkg::word_type'($urandom_range(0, 3000));
            default: ip = {$urandom, $urandom};
         endcase
         case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = '1;
            default: base = {$urandom, $urandom};
         endcase
         write_reg(cst_pkg::CSR_SITE_ENCODING, {$urandom, 24'($urandom), enc});
         write_reg(cst_pkg::CSR_SEARCH_PC, ip);
         write_reg(cst_pkg::CSR_PAD_BASE, base);
         if ($urandom_range(0, 9) == 0)
            write_reg(CSR_SPARE, {$urandom, $urandom});

         @(negedge clock);
         repeat ($urandom_range(4, 10)) begin
            case ($urandom_range(0, 7))
               0: begin
                  repeat ($urandom_range(1, 12)) put_byte(8'($urandom), 1'b0);
                  mark_end();
               end
               1:       put_table(enc, ip, 1'b1);
               default: put_table(enc, ip, 1'b0);
            endcase
         end
         rand_bytes += table_bytes.size();
         settle();
      end

      $display("tb: %0d table bytes taken, %0d register writes", bytes_taken, csr_writes);
      $display("tb: results %0d handler found, %0d no handler, %0d unsupported",
               n_found, n_none, n_unsupported);
      if (errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/cst_pkg.sv
hw/rtl/cst_req_if.sv
hw/rtl/cst_rsp_if.sv
hw/rtl/cst_csr_if.sv
hw/rtl/cst_front.sv
hw/rtl/cst_queue.sv
hw/rtl/cst_back.sv
hw/rtl/call_site_table_search_top.sv
tb/sv/tb.sv
